/* hdl/lagrange_basis_evaluator_unit_assert.svh */
// Assertion macros for the Lagrange basis evaluator checker.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef LAGRANGE_BASIS_EVALUATOR_UNIT_ASSERT_SVH
`define LAGRANGE_BASIS_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle property, disabled during reset.
`define LBEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent now, consequent on the next edge.
`define LBEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lbe_pkg.sv */
// Shared types and constants of the Lagrange basis evaluator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lbe_pkg;

  localparam int MAX_NODES_DEF = 16;

  localparam int NODE_W  = 16;  // Q2.14 node and point
  localparam int ACC_W   = 32;  // Q16.16 accumulator
  localparam int DIFF_W  = NODE_W + 1;
  localparam int PROD_W  = ACC_W + DIFF_W;
  localparam int QUO_W   = PROD_W - 1;  // product magnitude never exceeds 2^47
  localparam int DEN_W   = NODE_W;      // divisor magnitude never exceeds 65535
  localparam int CNTR_W  = 5;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CNTR_W-1:0] NODE_COUNT_RST = 5'd9;
  localparam logic signed [ACC_W-1:0] ACC_ONE = 32'sh0001_0000;
  localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7fff_ffff;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

  // Word index of each register.
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic {
    LBE_OP_LOAD = 1'b0,
    LBE_OP_EVAL = 1'b1
  } lbe_op_e;

  typedef enum logic [1:0] {
    LBE_ST_OK       = 2'd0,
    LBE_ST_SAT      = 2'd1,
    LBE_ST_ZERO_DEN = 2'd2,
    LBE_ST_RANGE    = 2'd3
  } lbe_status_e;

  typedef struct packed {
    lbe_op_e                   opcode;
    logic [3:0]                load_index;
    logic signed [NODE_W-1:0]  load_value;
    logic [3:0]                basis_index;
    logic signed [NODE_W-1:0]  eval_point;
  } lbe_cmd_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] basis_value;
    lbe_status_e             status;
  } lbe_result_t;

  typedef struct packed {
    logic             start;
    logic [QUO_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } lbe_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } lbe_div_rsp_t;

endpackage

`default_nettype wire

/* hdl/lagrange_basis_evaluator_unit.sv */
// Lagrange basis evaluator, top level: command port, APB register, sequencer.
// Depends on lbe_pkg, lbe_node_mem and lbe_divider.
//
// A load beat (start high, busy low, opcode load) writes one node in the cycle it is
// taken and keeps busy low. An in-range evaluate beat raises busy until its result;
// the result shows on result_o for exactly one cycle with result_valid_o high, and
// the receiver must take it then. An index out of range answers on the next cycle
// without raising busy. Otherwise the sequencer reads the node table one entry at a
// time (one port, registered read): it reads x_i, scans every node for a duplicate of
// x_i with a read and a check each, then for each of the other n-1 nodes reads it,
// multiplies and runs one pass of the radix-2 divider. A zero denominator ends at the
// scan. node_count sits at byte address 0.
`timescale 1ns / 1ps
`default_nettype none

module lagrange_basis_evaluator_unit #(
  parameter int MAX_NODES = lbe_pkg::MAX_NODES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire lbe_pkg::lbe_cmd_t                cmd_i,
  output logic                                  result_valid_o,
  output lbe_pkg::lbe_result_t                  result_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lbe_pkg::APB_AW-1:0]       paddr,
  input  wire logic [lbe_pkg::APB_DW-1:0]       pwdata,
  output logic [lbe_pkg::APB_DW-1:0]            prdata,
  output logic                                  pready
);
  import lbe_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int EW    = (CNT_W > CNTR_W) ? CNT_W : CNTR_W;
  localparam int BW    = (CNT_W > 4) ? CNT_W : 4;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_XI       = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CHK = 3'd3;
  localparam logic [2:0] S_MUL_RD   = 3'd4;
  localparam logic [2:0] S_MUL      = 3'd5;
  localparam logic [2:0] S_DIV_GO   = 3'd6;
  localparam logic [2:0] S_DIV_WAIT = 3'd7;

  // configuration register
  logic [CNTR_W-1:0] node_count_q;
  logic              reg_sel;

  assign reg_sel = (paddr[2] == REG_NODE_COUNT);
  assign pready  = 1'b1;
  assign prdata  = (psel && !pwrite && reg_sel) ? APB_DW'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      node_count_q <= pwdata[CNTR_W-1:0];
    end
  end

  // sequencer state
  logic [2:0]               state_q, state_d;
  logic [CNT_W-1:0]         m_q, m_d;
  logic [CNT_W-1:0]         n_q, n_d;
  logic [3:0]               bi_q, bi_d;
  logic signed [NODE_W-1:0] v_q, v_d;
  logic signed [NODE_W-1:0] xi_q, xi_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     sat_q, sat_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DIFF_W-1:0] den_q, den_d;
  logic                     res_valid_q, res_valid_d;
  lbe_result_t              res_q, res_d;

  logic                     eval_acc;
  logic                     load_acc;
  logic [CNT_W-1:0]         n_eff;
  logic                     out_of_range;
  logic                     m_is_bi;
  logic                     m_last;
  logic [IDX_W-1:0]         mem_raddr;
  logic signed [NODE_W-1:0] mem_rdata;
  logic signed [DIFF_W-1:0] num;
  logic signed [PROD_W-1:0] prod_abs;
  logic signed [DIFF_W-1:0] den_abs;
  logic                     neg;
  logic signed [PROD_W-1:0] qs;
  logic                     ovf;
  logic signed [ACC_W-1:0]  acc_step;
  lbe_div_req_t             div_req;
  lbe_div_rsp_t             div_rsp;

  assign busy     = (state_q != S_IDLE);
  assign eval_acc = start && !busy && (cmd_i.opcode == LBE_OP_EVAL);
  assign load_acc = start && !busy && (cmd_i.opcode == LBE_OP_LOAD);

  assign n_eff = (EW'(node_count_q) > EW'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                        : CNT_W'(node_count_q);
  assign out_of_range = (BW'(cmd_i.basis_index) >= BW'(n_eff));
  assign m_is_bi      = (BW'(m_q) == BW'(bi_q));
  assign m_last       = ((m_q + CNT_W'(1)) == n_q);

  lbe_node_mem #(
    .Depth(MAX_NODES)
  ) u_node_mem (
    .clk_i  (clk_i),
    .we_i   (load_acc && (int'(cmd_i.load_index) < MAX_NODES)),
    .waddr_i(IDX_W'(cmd_i.load_index)),
    .wdata_i(cmd_i.load_value),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // divider operands: magnitudes of the held product and denominator
  assign prod_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;
  assign den_abs  = den_q[DIFF_W-1] ? -den_q : den_q;
  assign neg      = prod_q[PROD_W-1] ^ den_q[DIFF_W-1];

  assign div_req.dividend = prod_abs[QUO_W-1:0];
  assign div_req.divisor  = den_abs[DEN_W-1:0];
  assign div_req.start    = (state_q == S_DIV_GO);

  lbe_divider u_divider (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // sign the quotient and clamp it to 32 bits
  assign qs  = neg ? -PROD_W'(div_rsp.quotient) : PROD_W'(div_rsp.quotient);
  assign ovf = !((&qs[PROD_W-1:ACC_W-1]) || !(|qs[PROD_W-1:ACC_W-1]));
  assign acc_step = ovf ? (qs[PROD_W-1] ? ACC_MIN : ACC_MAX) : qs[ACC_W-1:0];

  assign num = DIFF_W'(v_q) - DIFF_W'(mem_rdata);

  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    n_d         = n_q;
    bi_d        = bi_q;
    v_d         = v_q;
    xi_d        = xi_q;
    acc_d       = acc_q;
    sat_d       = sat_q;
    prod_d      = prod_q;
    den_d       = den_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_raddr   = m_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        mem_raddr = IDX_W'(cmd_i.basis_index);
        if (eval_acc) begin
          bi_d  = cmd_i.basis_index;
          v_d   = cmd_i.eval_point;
          n_d   = n_eff;
          acc_d = ACC_ONE;
          sat_d = 1'b0;
          if (out_of_range) begin
            res_valid_d       = 1'b1;
            res_d.basis_value = '0;
            res_d.status      = LBE_ST_RANGE;
          end else begin
            state_d = S_XI;
          end
        end
      end
      S_XI: begin
        xi_d    = mem_rdata;
        m_d     = '0;
        state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!m_is_bi && (mem_rdata == xi_q)) begin
          res_valid_d       = 1'b1;
          res_d.basis_value = '0;
          res_d.status      = LBE_ST_ZERO_DEN;
          state_d           = S_IDLE;
        end else if (m_last) begin
          m_d     = '0;
          state_d = S_MUL_RD;
        end else begin
          m_d     = m_q + CNT_W'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_MUL_RD: begin
        if (!m_is_bi) begin
          state_d = S_MUL;
        end else if (m_last) begin
          res_valid_d       = 1'b1;
          res_d.basis_value = acc_q;
          res_d.status      = sat_q ? LBE_ST_SAT : LBE_ST_OK;
          state_d           = S_IDLE;
        end else begin
          // skip the basis node itself
          m_d = m_q + CNT_W'(1);
        end
      end
      S_MUL: begin
        prod_d  = PROD_W'(acc_q) * PROD_W'(num);
        den_d   = DIFF_W'(xi_q) - DIFF_W'(mem_rdata);
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          acc_d = acc_step;
          sat_d = sat_q || ovf;
          if (m_last) begin
            res_valid_d       = 1'b1;
            res_d.basis_value = acc_step;
            res_d.status      = (sat_q || ovf) ? LBE_ST_SAT : LBE_ST_OK;
            state_d           = S_IDLE;
          end else begin
            m_d     = m_q + CNT_W'(1);
            state_d = S_MUL_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      m_q         <= '0;
      n_q         <= '0;
      sat_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      m_q         <= m_d;
      n_q         <= n_d;
      sat_q       <= sat_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bi_q   <= bi_d;
    v_q    <= v_d;
    xi_q   <= xi_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    den_q  <= den_d;
    res_q  <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

/* hdl/lbe_node_mem.sv */
// Node table: one write port, one registered read port, no reset on the array.
// Depends on lbe_pkg for the node width.
`timescale 1ns / 1ps
`default_nettype none

module lbe_node_mem #(
  parameter int Depth = lbe_pkg::MAX_NODES_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [$clog2(Depth)-1:0]              waddr_i,
  input  wire logic signed [lbe_pkg::NODE_W-1:0]     wdata_i,
  input  wire logic [$clog2(Depth)-1:0]              raddr_i,
  output logic signed [lbe_pkg::NODE_W-1:0]          rdata_o
);
  import lbe_pkg::*;

  logic signed [NODE_W-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hdl/lbe_divider.sv */
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on lbe_pkg for operand widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module lbe_divider (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lbe_pkg::lbe_div_req_t req_i,
  output lbe_pkg::lbe_div_rsp_t      rsp_o
);
  import lbe_pkg::*;

  localparam int CW = $clog2(QUO_W);
  localparam logic [CW-1:0] LAST = CW'(QUO_W - 1);

  logic [QUO_W-1:0] dvd_q, dvd_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] dsr_q, dsr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           qbit;

  always_comb begin
    trial = {rem_q, dvd_q[QUO_W-1]};
    diff  = trial - {1'b0, dsr_q};
    qbit  = ~diff[DEN_W];

    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;

    if (req_i.start) begin
      dvd_d = req_i.dividend;
      dsr_d = req_i.divisor;
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      // remainder stays below the divisor, so its low bits hold it
      rem_d = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dvd_d = {dvd_q[QUO_W-2:0], qbit};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

`default_nettype wire

/* hdl/lagrange_basis_evaluator_unit_checker.sv */
// Port-level checks of the Lagrange basis evaluator, bound to the top level.
// Depends on lbe_pkg and lagrange_basis_evaluator_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "lagrange_basis_evaluator_unit_assert.svh"

module lagrange_basis_evaluator_unit_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start,
  input wire logic                 busy,
  input wire lbe_pkg::lbe_cmd_t    cmd_i,
  input wire logic                 result_valid_o,
  input wire lbe_pkg::lbe_result_t result_o
);
  import lbe_pkg::*;

  // an evaluate beat either starts work or answers at once
  `LBEU_ASSERT_NEXT(a_eval_responds, start && !busy && cmd_i.opcode == LBE_OP_EVAL, busy || result_valid_o, "evaluate beat neither busy nor answered")

  // a result beat marks the end of the work
  `LBEU_ASSERT(a_result_idle, result_valid_o |-> !busy, "result beat while still busy")

  // work never ends without a result beat
  `LBEU_ASSERT(a_busy_fall_result, $fell(busy) |-> result_valid_o, "busy dropped without a result beat")

  // error results carry a zero value
  `LBEU_ASSERT(a_error_zero, result_valid_o && (result_o.status == LBE_ST_ZERO_DEN || result_o.status == LBE_ST_RANGE) |-> result_o.basis_value == '0, "error result with nonzero value")

endmodule

bind lagrange_basis_evaluator_unit lagrange_basis_evaluator_unit_checker u_checker (.*);

`default_nettype wire
